// File: src/c_string_escape_encoder_unit_macros.svh
// Assertion helpers used by the escape encoder back end (cse_back).
`ifndef C_STRING_ESCAPE_ENCODER_UNIT_MACROS_SVH
`define C_STRING_ESCAPE_ENCODER_UNIT_MACROS_SVH

// Same-cycle implication, clocked on aclk, off while in reset.
`define CSE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("cse check failed");

// Next-cycle implication, clocked on aclk, off while in reset.
`define CSE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("cse check failed");

`endif

// File: src/cse_pkg.sv
package cse_pkg;

    // Register indexes of the configuration port
    localparam logic [2:0] CFG_OPTIONS = 3'd0;
    localparam logic [2:0] CFG_MASK0   = 3'd1;
    localparam logic [2:0] CFG_MASK1   = 3'd2;
    localparam logic [2:0] CFG_MASK2   = 3'd3;
    localparam logic [2:0] CFG_MASK3   = 3'd4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // escape_options bits
    localparam int OPT_LIKE_C        = 0;
    localparam int OPT_UNICODE       = 1;
    localparam int OPT_HEX           = 2;
    localparam int OPT_NONPRINT_ONLY = 3;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       string_end;
    } out_item_t;

    typedef struct packed {
        logic [3:0]       options;
        logic [3:0][63:0] mask;
    } cfg_t;

    typedef enum logic [1:0] {
        KIND_PASS,
        KIND_CLIKE,
        KIND_UNI,
        KIND_HEX
    } kind_t;

    // One classified item on its way from front to back
    typedef struct packed {
        logic [7:0] raw;
        logic [7:0] sec;
        kind_t      kind;
        logic [2:0] last_idx;
        logic       str_end;
    } cmd_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] d;
        if (nib < 4'd10) begin
            d = 8'h30 + {4'd0, nib};
        end else begin
            d = 8'h57 + {4'd0, nib};
        end
        return d;
    endfunction

    // Letter of the two-character control escapes; zero where there is none
    function automatic logic [7:0] ctrl_letter(input logic [7:0] b);
        logic [7:0] l;
        case (b)
            8'h0A: begin
                l = 8'h6E;
            end
            8'h0D: begin
                l = 8'h72;
            end
            8'h08: begin
                l = 8'h62;
            end
            8'h0C: begin
                l = 8'h66;
            end
            8'h09: begin
                l = 8'h74;
            end
            8'h07: begin
                l = 8'h61;
            end
            default: begin
                l = 8'h00;
            end
        endcase
        return l;
    endfunction

endpackage

// File: src/cse_front.sv
module cse_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  cse_pkg::cfg_t     cfg,
    input  logic              s_valid,
    output logic              s_ready,
    input  cse_pkg::in_item_t s_data,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output cse_pkg::cmd_t     cmd
);

    logic          valid_reg, valid_next;
    cse_pkg::cmd_t cmd_reg, cmd_next;
    logic          accept;
    logic          printable, member, eligible, clike_ok;
    logic [7:0]    b;

    assign b         = s_data.in_byte;
    assign s_ready   = !valid_reg || cmd_ready;
    assign accept    = s_valid && s_ready;
    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

    always_comb begin
        printable = b inside {[8'h20:8'h7E]};
        member    = cfg.mask[b[7:6]][b[5:0]];
        eligible  = member && !(cfg.options[cse_pkg::OPT_NONPRINT_ONLY] && printable);
        clike_ok  = printable || (b inside {8'h0A, 8'h0D, 8'h08, 8'h0C, 8'h09, 8'h07});

        cmd_next.raw      = b;
        cmd_next.str_end  = s_data.in_end;
        cmd_next.sec      = printable ? b : cse_pkg::ctrl_letter(b);
        cmd_next.kind     = cse_pkg::KIND_PASS;
        cmd_next.last_idx = 3'd0;
        // Rules in priority order: c-like, unicode, hex
        if (eligible && cfg.options[cse_pkg::OPT_LIKE_C] && clike_ok) begin
            cmd_next.kind     = cse_pkg::KIND_CLIKE;
            cmd_next.last_idx = 3'd1;
        end else if (eligible && cfg.options[cse_pkg::OPT_UNICODE] && !printable) begin
            cmd_next.kind     = cse_pkg::KIND_UNI;
            cmd_next.last_idx = 3'd5;
        end else if (eligible && cfg.options[cse_pkg::OPT_HEX]) begin
            cmd_next.kind     = cse_pkg::KIND_HEX;
            cmd_next.last_idx = (b >= 8'h10) ? 3'd3 : 3'd2;
        end

        valid_next = accept || (valid_reg && !cmd_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

// File: src/cse_queue.sv
module cse_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  cse_pkg::cmd_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output cse_pkg::cmd_t pop_data
);

    cse_pkg::cmd_t                    mem_reg [cse_pkg::QUEUE_DEPTH];
    logic [cse_pkg::QUEUE_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [cse_pkg::QUEUE_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [cse_pkg::QUEUE_CNT_W-1:0]  count_reg, count_next;
    logic                             push, pop;

    localparam logic [cse_pkg::QUEUE_PTR_W-1:0] PTR_MAX =
        cse_pkg::QUEUE_PTR_W'(cse_pkg::QUEUE_DEPTH - 1);
    localparam logic [cse_pkg::QUEUE_CNT_W-1:0] CNT_FULL =
        cse_pkg::QUEUE_CNT_W'(cse_pkg::QUEUE_DEPTH);

    assign push_ready = count_reg != CNT_FULL;
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_MAX) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_MAX) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: src/cse_back.sv
`include "c_string_escape_encoder_unit_macros.svh"

module cse_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  cse_pkg::cmd_t      cmd,
    output logic               m_valid,
    input  logic               m_ready,
    output cse_pkg::out_item_t m_data
);

    logic               m_valid_reg, m_valid_next;
    cse_pkg::out_item_t m_data_reg, m_data_next;
    logic [2:0]         idx_reg, idx_next;
    logic               out_free, load, gen_last;
    logic [7:0]         gen_byte;

    assign out_free  = !m_valid_reg || m_ready;
    assign load      = cmd_valid && out_free;
    assign gen_last  = idx_reg == cmd.last_idx;
    assign cmd_ready = load && gen_last;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_comb begin
        case (cmd.kind)
            cse_pkg::KIND_PASS: begin
                gen_byte = cmd.raw;
            end
            cse_pkg::KIND_CLIKE: begin
                gen_byte = (idx_reg == 3'd0) ? cse_pkg::CH_BSLASH : cmd.sec;
            end
            cse_pkg::KIND_UNI: begin
                case (idx_reg)
                    3'd0: begin
                        gen_byte = cse_pkg::CH_BSLASH;
                    end
                    3'd1: begin
                        gen_byte = cse_pkg::CH_U;
                    end
                    3'd2, 3'd3: begin
                        gen_byte = cse_pkg::CH_ZERO;
                    end
                    3'd4: begin
                        gen_byte = cse_pkg::hex_digit(cmd.raw[7:4]);
                    end
                    default: begin
                        gen_byte = cse_pkg::hex_digit(cmd.raw[3:0]);
                    end
                endcase
            end
            cse_pkg::KIND_HEX: begin
                if (idx_reg == 3'd0) begin
                    gen_byte = cse_pkg::CH_BSLASH;
                end else if (idx_reg == 3'd1) begin
                    gen_byte = cse_pkg::CH_X;
                end else if (!gen_last) begin
                    gen_byte = cse_pkg::hex_digit(cmd.raw[7:4]);
                end else begin
                    gen_byte = cse_pkg::hex_digit(cmd.raw[3:0]);
                end
            end
            default: begin
                gen_byte = cmd.raw;
            end
        endcase

        m_data_next.out_byte   = gen_byte;
        m_data_next.run_last   = gen_last;
        m_data_next.string_end = gen_last && cmd.str_end;

        // hold the counter unless a byte goes into the output register
        idx_next = idx_reg;
        if (load) begin
            idx_next = gen_last ? 3'd0 : idx_reg + 3'd1;
        end
        m_valid_next = load || (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            idx_reg     <= 3'd0;
        end else begin
            m_valid_reg <= m_valid_next;
            idx_reg     <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg <= m_data_next;
        end
    end

    `CSE_ASSERT_IMP(a_idx_in_range, cmd_valid, idx_reg <= cmd.last_idx)
    `CSE_ASSERT_IMP(a_mid_item_held, idx_reg != 3'd0, cmd_valid)
    `CSE_ASSERT_NXT(a_last_rewinds, load && gen_last, idx_reg == 3'd0 && m_data_reg.run_last)

endmodule

// File: src/c_string_escape_encoder_unit.sv
// A byte accepted at the input passes the front command register, the queue and the
// back-end output register. Throughput with m_ready high: one input byte per cycle while
// bytes pass through; an escaped byte expands to 2 to 6 output bytes, one per cycle from
// the back-end expansion counter, with a two-entry queue absorbing front/back skew.
// Reset: synchronous, active low; clears the configuration, the queue and all valids.
module c_string_escape_encoder_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [cse_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cse_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  cse_pkg::in_item_t                s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output cse_pkg::out_item_t               m_data
);

    cse_pkg::cfg_t cfg_reg;
    logic          f_valid, f_ready, q_valid, q_ready;
    cse_pkg::cmd_t f_cmd, q_cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                cse_pkg::CFG_OPTIONS: begin
                    cfg_reg.options <= cfg_wr_data[3:0];
                end
                cse_pkg::CFG_MASK0: begin
                    cfg_reg.mask[0] <= cfg_wr_data;
                end
                cse_pkg::CFG_MASK1: begin
                    cfg_reg.mask[1] <= cfg_wr_data;
                end
                cse_pkg::CFG_MASK2: begin
                    cfg_reg.mask[2] <= cfg_wr_data;
                end
                cse_pkg::CFG_MASK3: begin
                    cfg_reg.mask[3] <= cfg_wr_data;
                end
                default: begin
                    // drop writes to unknown registers
                end
            endcase
        end
    end

    cse_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd       (f_cmd)
    );

    cse_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_cmd)
    );

    cse_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
